// ----- rtl/ccbd_pkg.sv -----
package ccbd_pkg;

  // Memory sizes
  localparam int unsigned RAM_DEPTH_DEF     = 2048;
  localparam int unsigned PROGRAM_DEPTH_DEF = 32768;

  // Bus widths
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IN_DW    = 40;
  localparam int unsigned OUT_DW   = 40;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned PPU_RW   = 3;

  // Decode constants
  localparam logic [ADDR_W-1:0] DMA_REG_ADDR = 16'h4014;
  localparam logic [ADDR_W-1:0] PAD_ADDR     = 16'h4016;
  localparam logic [2:0]        RAM_REGION   = 3'b000;
  localparam logic [2:0]        PPU_REGION   = 3'b001;
  localparam logic [BYTE_W-1:0] DMA_LAST_IDX = 8'hFF;

  // Beat kinds on the input side
  typedef enum logic [ACT_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic commit;
  } ccbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } ccbd_stat_t;

endpackage

// ----- rtl/ccbd_ram.sv -----
module ccbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ccbd_ctrl.sv -----
module ccbd_ctrl
  import ccbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ccbd_stat_t stat,
  output ccbd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_RD   = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.clr_wr  = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/ccbd_dp.sv -----
module ccbd_dp
  import ccbd_pkg::*;
#(
  parameter int unsigned RAM_DEPTH     = RAM_DEPTH_DEF,
  parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ccbd_cmd_t         cmd,
  output ccbd_stat_t        stat,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [IN_DW-1:0]  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_DW-1:0] out_data
);

  localparam int unsigned RAW = $clog2(RAM_DEPTH);
  localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);

  // Captured beat
  action_t           act_r;
  logic [ADDR_W-1:0] eff_addr_r;
  logic [BYTE_W-1:0] wdata_r;
  logic [BYTE_W-1:0] ppu_r;
  logic [BYTE_W-1:0] pad_r;

  // Architectural state
  logic [BYTE_W-1:0] pad_shift_r [2];
  logic [BYTE_W-1:0] src_page_r;
  logic [BYTE_W-1:0] dma_idx_r;
  logic              dma_busy_r;
  logic [RAW-1:0]    clr_cnt_r;

  // Output register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] ram_q, prog_q;
  logic              is_ram, is_ppu, is_pad, is_dma_reg, is_prog;
  logic              do_fetch, do_write, do_tick;
  logic [BYTE_W-1:0] rd_byte;
  logic              busy_nxt;
  logic [OUT_DW-1:0] res;
  logic              work_we, prog_we;
  logic [RAW-1:0]    work_waddr;
  logic [BYTE_W-1:0] work_wdata;

  assign in_addr = in_data[ADDR_W-1:0];

  // Capture the beat; a DMA tick takes its address from page and index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= action_t'(in_action);
      eff_addr_r <= (in_action == ACT_TICK) ? {src_page_r, dma_idx_r} : in_addr;
      wdata_r    <= in_data[ADDR_W +: BYTE_W];
      ppu_r      <= in_data[ADDR_W+BYTE_W +: BYTE_W];
      pad_r      <= in_data[ADDR_W+2*BYTE_W +: BYTE_W];
    end
  end

  // Address decode
  assign is_ram     = eff_addr_r[15:13] == RAM_REGION;
  assign is_ppu     = eff_addr_r[15:13] == PPU_REGION;
  assign is_pad     = eff_addr_r[15:1] == PAD_ADDR[15:1];
  assign is_dma_reg = eff_addr_r == DMA_REG_ADDR;
  assign is_prog    = eff_addr_r[15];

  assign do_write = act_r == ACT_WRITE;
  assign do_tick  = (act_r == ACT_TICK) && dma_busy_r;
  assign do_fetch = (act_r == ACT_READ) || do_tick;

  // Memories
  assign work_we    = cmd.clr_wr || (cmd.commit && do_write && is_ram);
  assign work_waddr = cmd.clr_wr ? clr_cnt_r : eff_addr_r[RAW-1:0];
  assign work_wdata = cmd.clr_wr ? '0 : wdata_r;
  assign prog_we    = cmd.commit && do_write && is_prog;

  ccbd_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (eff_addr_r[RAW-1:0]),
    .rdata (ram_q)
  );

  ccbd_ram #(.WIDTH(BYTE_W), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (eff_addr_r[PAW-1:0]),
    .wdata (wdata_r),
    .raddr (eff_addr_r[PAW-1:0]),
    .rdata (prog_q)
  );

  // Read mux
  always_comb begin
    priority if (is_ram) begin
      rd_byte = ram_q;
    end else if (is_ppu) begin
      rd_byte = ppu_r;
    end else if (is_pad) begin
      rd_byte = {{(BYTE_W-1){1'b0}}, pad_shift_r[eff_addr_r[0]][BYTE_W-1]};
    end else if (is_prog) begin
      rd_byte = prog_q;
    end else begin
      rd_byte = '0;
    end
  end

  // DMA busy after this beat
  always_comb begin
    busy_nxt = dma_busy_r;
    if (do_write && is_dma_reg) begin
      busy_nxt = 1'b1;
    end else if (do_tick && dma_idx_r == DMA_LAST_IDX) begin
      busy_nxt = 1'b0;
    end
  end

  // Result fields, lowest first
  always_comb begin
    res = '0;
    if (do_fetch) begin
      res[7:0]   = rd_byte;
      res[8]     = is_ppu;
      res[12:10] = is_ppu ? eff_addr_r[PPU_RW-1:0] : '0;
    end
    if (do_write && is_ppu) begin
      res[8]     = 1'b1;
      res[9]     = 1'b1;
      res[12:10] = eff_addr_r[PPU_RW-1:0];
      res[20:13] = wdata_r;
    end
    if (do_tick) begin
      res[21]    = 1'b1;
      res[29:22] = dma_idx_r;
      res[37:30] = rd_byte;
    end
    res[38] = busy_nxt;
  end

  // State updates on commit, clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_shift_r[0] <= '0;
      pad_shift_r[1] <= '0;
      src_page_r     <= '0;
      dma_idx_r      <= '0;
      dma_busy_r     <= 1'b0;
      clr_cnt_r      <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        dma_busy_r <= busy_nxt;
        if (do_write && is_pad) begin
          pad_shift_r[eff_addr_r[0]] <= pad_r;
        end else if (do_fetch && is_pad) begin
          pad_shift_r[eff_addr_r[0]] <= {pad_shift_r[eff_addr_r[0]][BYTE_W-2:0], 1'b0};
        end
        if (do_write && is_dma_reg) begin
          src_page_r <= wdata_r;
          dma_idx_r  <= '0;
        end else if (do_tick) begin
          dma_idx_r <= dma_idx_r + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.clr_last = clr_cnt_r == RAW'(RAM_DEPTH - 1);

endmodule

// ----- rtl/console_cpu_bus_decoder_with_oam_dma.sv -----
// CPU bus decoder with sprite DMA. Each input beat is a CPU read, a CPU write or a DMA
// tick (in_tuser) and gives exactly one output beat. An access is captured on acceptance,
// then does one registered read of work RAM and program store, then commits, updating
// state and loading the result register; no new beat is taken until the commit. A result
// waiting on out_tready holds the next access in its commit cycle. After reset the work
// RAM is zeroed, all RAM_DEPTH (2048) entries, with in_tready low. Program store
// contents are undefined until written.
module console_cpu_bus_decoder_with_oam_dma
  import ccbd_pkg::*;
#(
  parameter int unsigned RAM_DEPTH     = RAM_DEPTH_DEF,
  parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // address[15:0], write_data[23:16], ppu_data[31:24], pad_byte[39:32]
  input  logic [IN_DW-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]  in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // read_data[7:0], ppu_access[8], ppu_write[9], ppu_register[12:10],
  // ppu_write_data[20:13], oam_write[21], oam_index[29:22], oam_data[37:30],
  // dma_active[38], zero[39]
  output logic [OUT_DW-1:0] out_tdata
);

  ccbd_cmd_t  cmd;
  ccbd_stat_t stat;

  ccbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccbd_dp #(
    .RAM_DEPTH     (RAM_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- rtl/ccbd_checker.sv -----
module ccbd_checker
  import ccbd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // One access at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an access is in flight");

  // A PPU write is a PPU access
  a_ppu_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("ppu write without ppu access");

  // OAM byte equals fetched byte
  a_oam_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[37:30] == out_tdata[7:0])
    else $error("oam data differs from fetched byte");

  // DMA stays active until the last index
  a_dma_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] && out_tdata[29:22] != DMA_LAST_IDX |-> out_tdata[38])
    else $error("dma ended before last index");

endmodule

bind console_cpu_bus_decoder_with_oam_dma ccbd_checker u_ccbd_checker (.*);
